// ----- design/olst_pkg.sv -----
// Shared types and codes for the ordered list store.
package olst_pkg;

   localparam int VALUE_W    = 32;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int FILL_OUT_W = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND  = 3'd0,
      REQ_PREPEND = 3'd1,
      REQ_SORTED  = 3'd2,
      REQ_DUMP    = 3'd3,
      REQ_CLEAR   = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_ELEM  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD = 3'd0,
      CELL_LOAD = 3'd1,
      CELL_PREV = 3'd2,
      CELL_NEXT = 3'd3,
      CELL_HEAD = 3'd4
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

endpackage

// ----- design/olst_cell.sv -----
// One storage cell of the ordered list: holds a value, compares, shifts.
module olst_cell (
   input  logic                                clock,
   input  olst_pkg::cell_op_type               op,
   input  logic signed [olst_pkg::VALUE_W-1:0] new_value,
   input  logic signed [olst_pkg::VALUE_W-1:0] prev_value,
   input  logic signed [olst_pkg::VALUE_W-1:0] next_value,
   input  logic signed [olst_pkg::VALUE_W-1:0] head_value,
   output logic signed [olst_pkg::VALUE_W-1:0] value,
   output logic                                greater
);
   import olst_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (op)
         CELL_HOLD: value_in = value_ff;
         CELL_LOAD: value_in = new_value;
         CELL_PREV: value_in = prev_value;
         CELL_NEXT: value_in = next_value;
         CELL_HEAD: value_in = head_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value   = value_ff;
   assign greater = value_ff > new_value;

endmodule

// ----- design/ordered_list_store.sv -----
// Ordered list store: top level with controller and a row of storage cells.
//
// Usage: items arrive on req_* (valid/ready) carrying a request code and a
// value; results leave on rsp_* (valid/ready). Append, prepend, sorted insert,
// clear and unused codes each give one result, registered, in the cycle after
// the item is taken; a new item can be taken every cycle while the output
// register is free or being drained. Sorted insert places the value before
// the first stored value that is strictly greater. An insert into a full
// store gives a full status and changes nothing. A dump of an empty store
// gives one empty result; otherwise it gives one result per stored value,
// head first, the first after the dump state is entered and the result is
// registered, then at most one per cycle, so a dump holds the block until the
// last is registered. During a dump the cell row rotates by one position per
// result and is back in order after the last one; no item is taken meanwhile.
// When the receiver stalls, the result stays in the output register and
// req_ready drops until it is taken. Reset empties the store and clears
// any pending result; the cell contents are not cleared.
module ordered_list_store #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [olst_pkg::REQ_W-1:0]             req_type,
   input  logic signed [olst_pkg::VALUE_W-1:0]    req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [olst_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [olst_pkg::VALUE_W-1:0]    rsp_element,
   output logic                                   rsp_last,
   output logic [olst_pkg::FILL_OUT_W-1:0]        rsp_fill
);
   import olst_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);

   state_type                  state_ff, state_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0]  rsp_element_ff, rsp_element_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [FILL_OUT_W-1:0]      rsp_fill_ff, rsp_fill_in;

   logic signed [VALUE_W-1:0]  vals [DEPTH];
   cell_op_type                ops [DEPTH];
   logic [DEPTH-1:0]           gt;
   logic [DEPTH-1:0]           occ;
   logic [DEPTH-1:0]           ext, lsb, geq;
   logic                       out_free, accept, full, dump_last;
   logic [FILL_W+FILL_OUT_W-1:0] fill_wide;
   req_code_type               req_code;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [VALUE_W-1:0] prev_v, next_v;
         if (g == 0) begin : g_first
            assign prev_v = req_value;
         end else begin : g_mid
            assign prev_v = vals[g-1];
         end
         if (g == DEPTH - 1) begin : g_end
            assign next_v = vals[g];
         end else begin : g_inner
            assign next_v = vals[g+1];
         end
         assign occ[g] = FILL_W'(g) < fill_ff;

         olst_cell u_cell (
            .clock      (clock),
            .op         (ops[g]),
            .new_value  (req_value),
            .prev_value (prev_v),
            .next_value (next_v),
            .head_value (vals[0]),
            .value      (vals[g]),
            .greater    (gt[g])
         );
      end
   endgenerate

   assign req_code  = req_code_type'(req_type);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = fill_ff == FILL_W'(DEPTH);
   assign dump_last = ({1'b0, cnt_ff} + (IDX_W+1)'(1)) == (IDX_W+1)'(fill_ff);

   // insertion point: lowest set bit of ext; the cell there loads, cells after it shift
   always_comb begin
      case (req_code) inside
         REQ_APPEND:  ext = ~occ;
         REQ_PREPEND: ext = '1;
         REQ_SORTED:  ext = gt | ~occ;
         default:     ext = '0;
      endcase
      lsb = ext & (~ext + DEPTH'(1));
      geq = ~(lsb - DEPTH'(1));
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      for (int i = 0; i < DEPTH; i++) begin
         ops[i] = CELL_HOLD;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_DONE;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               case (req_code) inside
                  REQ_APPEND, REQ_PREPEND, REQ_SORTED: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        fill_in = fill_ff + FILL_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                           if (lsb[i]) begin
                              ops[i] = CELL_LOAD;
                           end else if (geq[i]) begin
                              ops[i] = CELL_PREV;
                           end
                        end
                     end
                  end
                  REQ_DUMP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = '0;
                        state_in     = ST_DUMP;
                     end
                  end
                  REQ_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                     rsp_status_in = STAT_DONE;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_ELEM;
               rsp_element_in = vals[0];
               rsp_last_in    = dump_last;
               cnt_in         = cnt_ff + IDX_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (FILL_W'(i) + FILL_W'(1) < fill_ff) begin
                     ops[i] = CELL_NEXT;
                  end else if (FILL_W'(i) + FILL_W'(1) == fill_ff) begin
                     ops[i] = CELL_HEAD;
                  end
               end
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      fill_wide   = (FILL_W+FILL_OUT_W)'(fill_in);
      rsp_fill_in = (rsp_valid_in && !(rsp_valid_ff && !rsp_ready))
                    ? fill_wide[FILL_OUT_W-1:0] : rsp_fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_fill    = rsp_fill_ff;

endmodule
